// ===== hw/rtl/clm_pkg.sv =====
// ----------------------------------------------------------------------------
// clm_pkg
// Shared types and constants of the colour and light mask pixel stage.
// ----------------------------------------------------------------------------
`default_nettype none

package clm_pkg;

    // Configuration register map, one register per 32-bit word.
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    typedef enum logic [1:0] {
        REG_IMAGE_WIDTH     = 2'd0,
        REG_IMAGE_HEIGHT    = 2'd1,
        REG_COLOR_THRESHOLD = 2'd2,
        REG_LIGHT_THRESHOLD = 2'd3
    } t_reg_idx;

    localparam int CFG_DIM_W = 12;
    localparam int CFG_TH_W  = 8;
    localparam int ROW_IN_W  = CFG_DIM_W + 1;

    localparam logic [CFG_DIM_W-1:0] RST_IMAGE_WIDTH     = 12'd640;
    localparam logic [CFG_DIM_W-1:0] RST_IMAGE_HEIGHT    = 12'd480;
    localparam logic [CFG_TH_W-1:0]  RST_COLOR_THRESHOLD = 8'd70;
    localparam logic [CFG_TH_W-1:0]  RST_LIGHT_THRESHOLD = 8'd150;

    // Gray weights in Q14 with rounding.
    localparam int GRAY_W = 22;
    localparam logic [GRAY_W-1:0] GRAY_COEF_BLUE  = 22'd4899;
    localparam logic [GRAY_W-1:0] GRAY_COEF_GREEN = 22'd9617;
    localparam logic [GRAY_W-1:0] GRAY_COEF_RED   = 22'd1868;
    localparam logic [GRAY_W-1:0] GRAY_ROUND      = 22'd8192;
    localparam int GRAY_SHIFT = 14;

    localparam int PIX_DATA_W = 24;
    localparam int RES_DATA_W = 8;

    // Result queue depth: one slot per item in flight plus one being taken.
    localparam int OUT_DEPTH   = 3;
    localparam int OUT_PTR_W   = $clog2(OUT_DEPTH);
    localparam int OUT_COUNT_W = $clog2(OUT_DEPTH + 1);

    typedef struct packed {
        logic last_pixel;
        logic color_dilated;
        logic light_bit;
        logic mask;
    } t_result;

endpackage

`default_nettype wire

// ===== hw/rtl/clm_out_fifo.sv =====
// ----------------------------------------------------------------------------
// clm_out_fifo
// Small result queue that decouples the pixel pipeline from the output stream.
// ----------------------------------------------------------------------------
`default_nettype none

module clm_out_fifo (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_push,
    input  clm_pkg::t_result                   i_data,
    input  wire                                i_pop_ready,
    output logic                               o_valid,
    output clm_pkg::t_result                   o_data,
    output logic [clm_pkg::OUT_COUNT_W-1:0]    o_count
);

    clm_pkg::t_result                  r_entry [clm_pkg::OUT_DEPTH];
    logic [clm_pkg::OUT_PTR_W-1:0]     r_wr_ptr;
    logic [clm_pkg::OUT_PTR_W-1:0]     r_rd_ptr;
    logic [clm_pkg::OUT_COUNT_W-1:0]   r_count;
    logic [clm_pkg::OUT_PTR_W-1:0]     n_wr_ptr;
    logic [clm_pkg::OUT_PTR_W-1:0]     n_rd_ptr;
    logic [clm_pkg::OUT_COUNT_W-1:0]   n_count;
    logic                              pop;

    localparam logic [clm_pkg::OUT_PTR_W-1:0] PTR_LAST =
        clm_pkg::OUT_PTR_W'(clm_pkg::OUT_DEPTH - 1);

    assign o_valid = (r_count != '0);
    assign o_data  = r_entry[r_rd_ptr];
    assign o_count = r_count;
    assign pop     = o_valid && i_pop_ready;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
        end
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entry[r_wr_ptr] <= i_data;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/color_light_mask_pixel_stage.sv =====
// ----------------------------------------------------------------------------
// color_light_mask_pixel_stage
// Colour and light thresholding with 3x3 dilation of the colour mask.
// ----------------------------------------------------------------------------
// Output: a result passes the stage 1 registers and the result queue after the
//   request that completes its neighbourhood, image_width + 1 requests after its pixel.
// Throughput: one request per cycle, set by the single read-modify-write of the line
//   memory per column; stalls when queued results plus a stage 1 request reach three.
// Reset (synchronous): clears counters, window, pipeline and result queue; the
//   line memory is not cleared, as rows outside the image are always masked.
`default_nettype none

module color_light_mask_pixel_stage #(
    parameter int MAX_WIDTH = 2048
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    // Pixel stream in
    input  wire                                s_axis_tvalid,
    output logic                               s_axis_tready,
    input  wire  [clm_pkg::PIX_DATA_W-1:0]     s_axis_tdata,   // blue, green, red
    input  wire                                s_axis_tuser,   // kind (1 = flush)
    // Result stream out
    output logic                               m_axis_tvalid,
    input  wire                                m_axis_tready,
    output logic [clm_pkg::RES_DATA_W-1:0]     m_axis_tdata,   // mask, light_bit,
                                                               // color_dilated, zeros
    output logic                               m_axis_tlast,   // last_pixel
    // Configuration
    input  wire                                psel,
    input  wire                                penable,
    input  wire                                pwrite,
    input  wire  [clm_pkg::APB_ADDR_W-1:0]     paddr,
    input  wire  [clm_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [clm_pkg::APB_DATA_W-1:0]     prdata,
    output logic                               pready
);

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int WID_W  = $clog2(MAX_WIDTH + 1);
    localparam int CMP_W  = (WID_W > clm_pkg::CFG_DIM_W) ? WID_W : clm_pkg::CFG_DIM_W;
    localparam int ROW_W  = clm_pkg::CFG_DIM_W;
    localparam int RIN_W  = clm_pkg::ROW_IN_W;
    localparam logic [CMP_W-1:0] MAX_W_EXT = CMP_W'(MAX_WIDTH);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [clm_pkg::CFG_DIM_W-1:0] r_cfg_width;
    logic [clm_pkg::CFG_DIM_W-1:0] r_cfg_height;
    logic [clm_pkg::CFG_TH_W-1:0]  r_cfg_color_th;
    logic [clm_pkg::CFG_TH_W-1:0]  r_cfg_light_th;
    logic                          cfg_wr;
    clm_pkg::t_reg_idx             reg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_idx = clm_pkg::t_reg_idx'(paddr[3:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_width    <= clm_pkg::RST_IMAGE_WIDTH;
            r_cfg_height   <= clm_pkg::RST_IMAGE_HEIGHT;
            r_cfg_color_th <= clm_pkg::RST_COLOR_THRESHOLD;
            r_cfg_light_th <= clm_pkg::RST_LIGHT_THRESHOLD;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                clm_pkg::REG_IMAGE_WIDTH: begin
                    r_cfg_width <= pwdata[clm_pkg::CFG_DIM_W-1:0];
                end
                clm_pkg::REG_IMAGE_HEIGHT: begin
                    r_cfg_height <= pwdata[clm_pkg::CFG_DIM_W-1:0];
                end
                clm_pkg::REG_COLOR_THRESHOLD: begin
                    r_cfg_color_th <= pwdata[clm_pkg::CFG_TH_W-1:0];
                end
                clm_pkg::REG_LIGHT_THRESHOLD: begin
                    r_cfg_light_th <= pwdata[clm_pkg::CFG_TH_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            clm_pkg::REG_IMAGE_WIDTH:     prdata = clm_pkg::APB_DATA_W'(r_cfg_width);
            clm_pkg::REG_IMAGE_HEIGHT:    prdata = clm_pkg::APB_DATA_W'(r_cfg_height);
            clm_pkg::REG_COLOR_THRESHOLD: prdata = clm_pkg::APB_DATA_W'(r_cfg_color_th);
            clm_pkg::REG_LIGHT_THRESHOLD: prdata = clm_pkg::APB_DATA_W'(r_cfg_light_th);
            default:                      prdata = '0;
        endcase
    end

    // Effective geometry: zero acts as one, width is capped at the line length.
    logic [CMP_W-1:0] cfg_width_ext;
    logic [WID_W-1:0] w_eff;
    logic [ROW_W-1:0] h_eff;

    assign cfg_width_ext = CMP_W'(r_cfg_width);

    always_comb begin
        if (r_cfg_width == '0) begin
            w_eff = WID_W'(1);
        end else if (cfg_width_ext > MAX_W_EXT) begin
            w_eff = WID_W'(MAX_WIDTH);
        end else begin
            w_eff = WID_W'(cfg_width_ext);
        end
        h_eff = (r_cfg_height == '0) ? ROW_W'(1) : r_cfg_height;
    end

    // ------------------------------------------------------------------
    // Stage 0: request decode, position counters, per-pixel thresholds
    // ------------------------------------------------------------------
    logic [COL_W-1:0] r_in_col,  n_in_col;
    logic [RIN_W-1:0] r_in_row,  n_in_row;
    logic [COL_W-1:0] r_out_col, n_out_col;
    logic [ROW_W-1:0] r_out_row, n_out_row;

    logic                   in_accept;
    logic                   geo_restart;
    logic [COL_W-1:0]       ic;
    logic [RIN_W-1:0]       ir;
    logic [COL_W-1:0]       oc;
    logic [ROW_W-1:0]       orow;
    logic                   draining;
    logic                   active;
    logic                   emit;
    logic                   top_edge;
    logic                   bot_edge;
    logic                   left_ok;
    logic                   right_ok;
    logic                   row_end;
    logic                   last;
    logic [7:0]             blue;
    logic [7:0]             green;
    logic [7:0]             red;
    logic [7:0]             diff;
    logic [clm_pkg::GRAY_W-1:0] gray_sum;
    logic [7:0]             gray;
    logic                   cbit;
    logic                   lbit;

    assign blue  = s_axis_tdata[7:0];
    assign green = s_axis_tdata[15:8];
    assign red   = s_axis_tdata[23:16];

    always_comb begin
        diff     = (blue > green) ? (blue - green) : 8'd0;
        gray_sum = clm_pkg::GRAY_COEF_BLUE  * clm_pkg::GRAY_W'(blue)
                 + clm_pkg::GRAY_COEF_GREEN * clm_pkg::GRAY_W'(green)
                 + clm_pkg::GRAY_COEF_RED   * clm_pkg::GRAY_W'(red)
                 + clm_pkg::GRAY_ROUND;
        gray     = gray_sum[clm_pkg::GRAY_W-1:clm_pkg::GRAY_SHIFT];
    end

    always_comb begin
        geo_restart = (WID_W'(r_in_col) >= w_eff) || (WID_W'(r_out_col) >= w_eff)
                   || (r_in_row > (RIN_W'(h_eff) + 1'b1)) || (r_out_row >= h_eff);
        ic   = geo_restart ? '0 : r_in_col;
        ir   = geo_restart ? '0 : r_in_row;
        oc   = geo_restart ? '0 : r_out_col;
        orow = geo_restart ? '0 : r_out_row;

        draining = (ir >= RIN_W'(h_eff));
        active   = draining || !s_axis_tuser;
        emit     = active && ((ir >= RIN_W'(2)) || ((ir == RIN_W'(1)) && (ic != '0)));
        cbit     = !draining && (diff > r_cfg_color_th);
        lbit     = !draining && (gray > r_cfg_light_th);

        top_edge = (orow == '0);
        bot_edge = ((RIN_W'(orow) + 1'b1) >= RIN_W'(h_eff));
        left_ok  = (oc != '0);
        right_ok = ((WID_W'(oc) + 1'b1) < w_eff);
        row_end  = ((WID_W'(ic) + 1'b1) >= w_eff);
        last     = emit && bot_edge && !right_ok;
    end

    always_comb begin
        n_in_col  = r_in_col;
        n_in_row  = r_in_row;
        n_out_col = r_out_col;
        n_out_row = r_out_row;
        if (in_accept) begin
            n_in_col  = ic;
            n_in_row  = ir;
            n_out_col = oc;
            n_out_row = orow;
            if (active) begin
                if (row_end) begin
                    n_in_col = '0;
                    n_in_row = ir + 1'b1;
                end else begin
                    n_in_col = ic + 1'b1;
                end
            end
            if (last) begin
                n_in_col  = '0;
                n_in_row  = '0;
                n_out_col = '0;
                n_out_row = '0;
            end else if (emit) begin
                if (!right_ok) begin
                    n_out_col = '0;
                    n_out_row = orow + 1'b1;
                end else begin
                    n_out_col = oc + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
        end else begin
            r_in_col  <= n_in_col;
            r_in_row  <= n_in_row;
            r_out_col <= n_out_col;
            r_out_row <= n_out_row;
        end
    end

    // ------------------------------------------------------------------
    // Line memory: per column {light of previous row, colour of previous
    // row, colour of the row before that}. Read in stage 0, written back
    // in stage 1.
    // ------------------------------------------------------------------
    logic [2:0]       r_line_mem [MAX_WIDTH];
    logic [2:0]       r_mem_q;
    logic             r_fwd;
    logic [2:0]       r_fwd_data;

    // Stage 1 registers
    logic             r_s1_valid;
    logic             r_s1_clr_pre;
    logic             r_s1_active;
    logic             r_s1_emit;
    logic             r_s1_col_zero;
    logic             r_s1_top;
    logic             r_s1_bot;
    logic             r_s1_left;
    logic             r_s1_right;
    logic             r_s1_last;
    logic             r_s1_cbit;
    logic             r_s1_lbit;
    logic [COL_W-1:0] r_s1_addr;

    logic [8:0]       r_win;
    logic             r_light_held;

    logic             s1_wr;
    logic [2:0]       s1_wdata;
    logic [2:0]       line_rd;
    logic [8:0]       win_in;
    logic             light_in;
    logic [8:0]       win_shift;
    logic [2:0]       row_sel;
    logic             dil;
    logic [8:0]       n_win;
    logic             n_light_held;
    clm_pkg::t_result s1_result;

    assign s1_wr    = r_s1_valid && r_s1_active;
    assign line_rd  = r_fwd ? r_fwd_data : r_mem_q;
    assign s1_wdata = {r_s1_lbit, r_s1_cbit, line_rd[1]};

    always_ff @(posedge i_clk) begin
        if (s1_wr) begin
            r_line_mem[r_s1_addr] <= s1_wdata;
        end
        r_mem_q    <= r_line_mem[ic];
        // Back-to-back requests on the same column (width of one, or a
        // restart onto column zero) see the write still in flight.
        r_fwd      <= s1_wr && (r_s1_addr == ic);
        r_fwd_data <= s1_wdata;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= in_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_clr_pre  <= geo_restart;
            r_s1_active   <= active;
            r_s1_emit     <= emit;
            r_s1_col_zero <= (ic == '0);
            r_s1_top      <= top_edge;
            r_s1_bot      <= bot_edge;
            r_s1_left     <= left_ok;
            r_s1_right    <= right_ok;
            r_s1_last     <= last;
            r_s1_cbit     <= cbit;
            r_s1_lbit     <= lbit;
            r_s1_addr     <= ic;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: window shift and 3x3 dilation
    // Window bit 3*k+j: column k (0 oldest), row j (0 upper, 2 current).
    // ------------------------------------------------------------------
    always_comb begin
        win_in    = r_s1_clr_pre ? 9'd0 : r_win;
        light_in  = r_s1_clr_pre ? 1'b0 : r_light_held;
        win_shift = {r_s1_cbit, line_rd[1], line_rd[0], win_in[8:3]};
        // Rows above the top and below the bottom of the image are ignored.
        row_sel   = {!r_s1_bot, 1'b1, !r_s1_top};

        if (r_s1_col_zero) begin
            // The right neighbour is outside the image: use the unshifted window.
            dil = |(win_in[8:6] & row_sel)
                | (r_s1_left && |(win_in[5:3] & row_sel));
        end else begin
            dil = |(win_shift[5:3] & row_sel)
                | (r_s1_left  && |(win_shift[2:0] & row_sel))
                | (r_s1_right && |(win_shift[8:6] & row_sel));
        end

        if (r_s1_active) begin
            n_win        = r_s1_last ? 9'd0 : win_shift;
            n_light_held = r_s1_last ? 1'b0 : line_rd[2];
        end else begin
            n_win        = win_in;
            n_light_held = light_in;
        end

        s1_result.mask          = dil && light_in;
        s1_result.light_bit     = light_in;
        s1_result.color_dilated = dil;
        s1_result.last_pixel    = r_s1_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win        <= '0;
            r_light_held <= 1'b0;
        end else if (r_s1_valid) begin
            r_win        <= n_win;
            r_light_held <= n_light_held;
        end
    end

    // ------------------------------------------------------------------
    // Result queue and flow control
    // ------------------------------------------------------------------
    logic [clm_pkg::OUT_COUNT_W-1:0] q_count;
    clm_pkg::t_result                q_data;

    clm_out_fifo u_out_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (r_s1_valid && r_s1_emit),
        .i_data      (s1_result),
        .i_pop_ready (m_axis_tready),
        .o_valid     (m_axis_tvalid),
        .o_data      (q_data),
        .o_count     (q_count)
    );

    // A request is taken only when a queue slot is sure to be free for it.
    assign s_axis_tready = ((clm_pkg::OUT_COUNT_W + 1)'(q_count)
                           + (clm_pkg::OUT_COUNT_W + 1)'(r_s1_valid))
                           < (clm_pkg::OUT_COUNT_W + 1)'(clm_pkg::OUT_DEPTH);
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    assign m_axis_tdata = {(clm_pkg::RES_DATA_W - 3)'(0), q_data.color_dilated,
                           q_data.light_bit, q_data.mask};
    assign m_axis_tlast = q_data.last_pixel;

endmodule

`default_nettype wire

// ===== hw/rtl/clm_checker.sv =====
// ----------------------------------------------------------------------------
// clm_checker
// Port-level checks of the colour and light mask pixel stage.
// ----------------------------------------------------------------------------
`default_nettype none

module clm_checker (
    input wire                              i_clk,
    input wire                              i_rst_n,
    input wire                              s_axis_tvalid,
    input wire                              s_axis_tready,
    input wire                              m_axis_tvalid,
    input wire                              m_axis_tready,
    input wire [clm_pkg::RES_DATA_W-1:0]    m_axis_tdata,
    input wire                              m_axis_tlast
);

    // A result held back by the sink stays unchanged.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("result changed while stalled");

    // Reset empties the result queue.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result offered straight after reset");

    // A result can only appear once a taken request has passed stage 1 and the queue.
    a_out_needs_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2))
        else $error("result appeared without a request");

    // Input back-pressure only arises while results are pending in the result queue.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("input stalled with no result pending");

endmodule

bind color_light_mask_pixel_stage clm_checker u_clm_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Colour and light mask pixel stage testbench
// Streams pixel frames of many geometries into the stage, predicts every
// result with a behavioural model of the line buffers and dilation window, or
// takes it from the directed table, and compares each result against it, field by field.
// ----------------------------------------------------------------------------
module testbench;
    import clm_pkg::*;

    localparam int LINE_MAX = 2048;
    localparam bit KIND_PIXEL = 1'b0;
    localparam bit KIND_FLUSH = 1'b1;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    wire                   s_axis_tready;
    logic [PIX_DATA_W-1:0] s_axis_tdata = '0;   // blue, green, red
    logic                  s_axis_tuser = 1'b0;  // kind
    wire                   m_axis_tvalid;
    logic                  m_axis_tready = 1'b1;
    wire  [RES_DATA_W-1:0] m_axis_tdata;        // mask, light_bit, color_dilated, zeros
    wire                   m_axis_tlast;        // last_pixel
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    wire  [APB_DATA_W-1:0] prdata;
    wire                   pready;

    color_light_mask_pixel_stage #(
        .MAX_WIDTH (LINE_MAX)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #5 i_clk = ~i_clk;

    // Predictor state: configuration, line buffers, window and counters.
    int unsigned cfg_width = 640;
    int unsigned cfg_height = 480;
    int unsigned cfg_colour_th = 70;
    int unsigned cfg_light_th = 150;
    bit          colour_row_older [LINE_MAX];
    bit          colour_row_newer [LINE_MAX];
    bit          light_row [LINE_MAX];
    bit          light_pending;
    logic [8:0]  nbhd_bits = '0;
    int unsigned pix_col, pix_row, res_col, res_row;

    t_result     mask_results_due [$];
    int unsigned fail_count = 0;
    int unsigned random_items = 0;
    bit          stalls_on = 1'b1;
    bit          calm = 1'b0;
    int unsigned rx_hold = 0;

    // Directed requests on a 1x1 image; want is {last, dilated, light, mask}.
    typedef struct packed {
        bit         kind;
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
        bit         typed;
        t_result    want;
    } directed_row_t;

    localparam int N_DIRECTED = 23;
    directed_row_t directed_rows [N_DIRECTED] = '{
        {KIND_FLUSH, 8'd0,   8'd0,   8'd0,   1'b0, 4'b0000},  // no frame yet: ignored
        {KIND_PIXEL, 8'd255, 8'd100, 8'd255, 1'b0, 4'b0000},
        {KIND_FLUSH, 8'd17,  8'd34,  8'd51,  1'b0, 4'b0000},
        {KIND_FLUSH, 8'd0,   8'd0,   8'd0,   1'b1, 4'b1111},
        {KIND_PIXEL, 8'd255, 8'd0,   8'd0,   1'b0, 4'b0000},
        {KIND_PIXEL, 8'd255, 8'd255, 8'd255, 1'b0, 4'b0000},  // pixel while draining
        {KIND_FLUSH, 8'd0,   8'd0,   8'd0,   1'b1, 4'b1100},
        {KIND_PIXEL, 8'd255, 8'd255, 8'd255, 1'b0, 4'b0000},
        {KIND_FLUSH, 8'd0,   8'd0,   8'd0,   1'b0, 4'b0000},
        {KIND_PIXEL, 8'd0,   8'd0,   8'd0,   1'b1, 4'b1010},
        {KIND_PIXEL, 8'd0,   8'd0,   8'd0,   1'b0, 4'b0000},
        {KIND_FLUSH, 8'd255, 8'd255, 8'd255, 1'b0, 4'b0000},
        {KIND_FLUSH, 8'd0,   8'd0,   8'd0,   1'b1, 4'b1000},
        {KIND_FLUSH, 8'd255, 8'd255, 8'd255, 1'b0, 4'b0000},  // ignored
        {KIND_PIXEL, 8'd0,   8'd255, 8'd0,   1'b0, 4'b0000},  // grey exactly 150
        {KIND_FLUSH, 8'd0,   8'd0,   8'd0,   1'b0, 4'b0000},
        {KIND_FLUSH, 8'd0,   8'd0,   8'd0,   1'b1, 4'b1000},
        {KIND_PIXEL, 8'd71,  8'd0,   8'd0,   1'b0, 4'b0000},
        {KIND_FLUSH, 8'd0,   8'd0,   8'd0,   1'b0, 4'b0000},
        {KIND_FLUSH, 8'd0,   8'd0,   8'd0,   1'b1, 4'b1100},
        {KIND_PIXEL, 8'd70,  8'd0,   8'd0,   1'b0, 4'b0000},
        {KIND_FLUSH, 8'd0,   8'd0,   8'd0,   1'b0, 4'b0000},
        {KIND_FLUSH, 8'd0,   8'd0,   8'd0,   1'b0, 4'b0000}
    };

    function automatic void note_failure(string msg);
        fail_count++;
        if (fail_count <= 10)
            $display("ERROR @%0t: %s", $realtime, msg);
    endfunction

    function automatic int unsigned eff_width();
        int unsigned w = cfg_width;
        if (w == 0) w = 1;
        if (w > LINE_MAX) w = LINE_MAX;
        return w;
    endfunction

    function automatic int unsigned eff_height();
        return (cfg_height == 0) ? 1 : cfg_height;
    endfunction

    function automatic void restart_frame();
        nbhd_bits = '0;
        light_pending = 1'b0;
        pix_col = 0;
        pix_row = 0;
        res_col = 0;
        res_row = 0;
    endfunction

    // OR of window column k (0 oldest, 2 newest) over rows j0 to j1.
    function automatic bit window_or(logic [8:0] win, int k, int j0, int j1);
        bit acc = 1'b0;
        for (int j = j0; j <= j1; j++)
            acc |= win[k * 3 + j];
        return acc;
    endfunction

    task automatic step_mask_model(input bit kind, input logic [PIX_DATA_W-1:0] pix,
                                   output bit produced, output t_result res);
        int unsigned w, h, c, orow, ocol, j0, j1, gray, diff, blue, green, red;
        bit          cbit, lbit, light_out, dil, last, emits;
        logic [8:0]  prev_win, shifted;
        w = eff_width();
        h = eff_height();
        blue = 32'(pix[7:0]);
        green = 32'(pix[15:8]);
        red = 32'(pix[23:16]);
        cbit = 1'b0;
        lbit = 1'b0;
        produced = 1'b0;
        res = '0;
        if (pix_col >= w || res_col >= w || pix_row > h + 1 || res_row >= h)
            restart_frame();
        // A flush while the frame still wants pixels leaves everything untouched.
        if (pix_row >= h || kind == KIND_PIXEL) begin
            if (pix_row < h) begin
                diff = (blue > green) ? blue - green : 0;
                gray = (4899 * blue + 9617 * green + 1868 * red + 8192) >> 14;
                cbit = diff > cfg_colour_th;
                lbit = gray > cfg_light_th;
            end
            c = pix_col;
            emits = pix_row >= 2 || (pix_row == 1 && c >= 1);
            prev_win = nbhd_bits;
            shifted = {cbit, colour_row_newer[c], colour_row_older[c], nbhd_bits[8:3]};
            colour_row_older[c] = colour_row_newer[c];
            colour_row_newer[c] = cbit;
            nbhd_bits = shifted;
            light_out = light_pending;
            light_pending = light_row[c];
            light_row[c] = lbit;
            if (c + 1 >= w) begin
                pix_col = 0;
                pix_row++;
            end else begin
                pix_col = c + 1;
            end
            if (emits) begin
                orow = res_row;
                ocol = res_col;
                j0 = (orow == 0) ? 1 : 0;
                j1 = (orow + 1 >= h) ? 1 : 2;
                if (c == 0) begin
                    // The right-hand neighbour is off the row, so the window has not moved on.
                    dil = window_or(prev_win, 2, j0, j1);
                    if (ocol > 0) dil |= window_or(prev_win, 1, j0, j1);
                end else begin
                    dil = window_or(shifted, 1, j0, j1);
                    if (ocol > 0) dil |= window_or(shifted, 0, j0, j1);
                    if (ocol + 1 < w) dil |= window_or(shifted, 2, j0, j1);
                end
                last = orow + 1 >= h && ocol + 1 >= w;
                res.mask = dil & light_out;
                res.light_bit = light_out;
                res.color_dilated = dil;
                res.last_pixel = last;
                produced = 1'b1;
                if (last) begin
                    restart_frame();
                end else if (ocol + 1 >= w) begin
                    res_col = 0;
                    res_row = orow + 1;
                end else begin
                    res_col = ocol + 1;
                end
            end
        end
    endtask

    task automatic apb_access(input bit wr, input t_reg_idx idx, input logic [31:0] wdata,
                              output logic [31:0] rdata);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= {idx, 2'b00};
        pwdata <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        rdata = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic check_reg(input t_reg_idx idx, input logic [31:0] want);
        logic [31:0] got;
        apb_access(1'b0, idx, '0, got);
        if (got !== want)
            note_failure($sformatf("%s reads %0d, expected %0d", idx.name(), got, want));
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic [31:0] value);
        logic [31:0] discard;
        apb_access(1'b1, idx, value, discard);
        case (idx)
            REG_IMAGE_WIDTH:     cfg_width = value & 32'hFFF;
            REG_IMAGE_HEIGHT:    cfg_height = value & 32'hFFF;
            REG_COLOR_THRESHOLD: cfg_colour_th = value & 32'hFF;
            REG_LIGHT_THRESHOLD: cfg_light_th = value & 32'hFF;
            default: ;
        endcase
        check_reg(idx, value);
    endtask

    task automatic set_config(input logic [31:0] w, input logic [31:0] h,
                              input logic [31:0] colour_th, input logic [31:0] light_th);
        write_reg(REG_IMAGE_WIDTH, w);
        write_reg(REG_IMAGE_HEIGHT, h);
        write_reg(REG_COLOR_THRESHOLD, colour_th);
        write_reg(REG_LIGHT_THRESHOLD, light_th);
    endtask

    // Leaves tvalid high after the request is taken; the caller lowers it.
    task automatic send_item(input bit kind, input logic [PIX_DATA_W-1:0] pix,
                             input bit typed = 1'b0, input t_result typed_res = '0);
        bit      produced;
        t_result res;
        if (stalls_on && !calm && $urandom_range(0, 5) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= pix;
        s_axis_tuser <= kind;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        step_mask_model(kind, pix, produced, res);
        if (produced)
            mask_results_due.push_back(typed ? typed_res : res);
    endtask

    // Whole frames of random pixels and drain requests, with stray flushes and
    // pixels mixed in; a non-zero cut_at below the frame length stops the last frame early.
    task automatic send_frames(input int unsigned frames, input int unsigned cut_at);
        int unsigned w, h, pixels, total, stop;
        w = eff_width();
        h = eff_height();
        pixels = w * h;
        total = pixels + w + 1;
        for (int unsigned f = 0; f < frames; f++) begin
            stop = (f + 1 == frames && cut_at != 0 && cut_at < total) ? cut_at : total;
            for (int unsigned k = 0; k < stop; k++) begin
                if (k < pixels) begin
                    if ($urandom_range(0, 19) == 0)
                        send_item(KIND_FLUSH, PIX_DATA_W'($urandom));
                    send_item(KIND_PIXEL, PIX_DATA_W'($urandom));
                end else begin
                    send_item(($urandom_range(0, 7) == 0) ? KIND_PIXEL : KIND_FLUSH,
                              PIX_DATA_W'($urandom));
                end
                random_items++;
            end
        end
    endtask

    // A request that completes no result may still be in the pipeline, so keep
    // waiting after the last result before touching registers.
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (mask_results_due.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (rx_hold != 0) begin
            rx_hold <= rx_hold - 1;
        end else if (stalls_on && !calm && $urandom_range(0, 3) == 0) begin
            m_axis_tready <= 1'b0;
            rx_hold <= $urandom_range(0, 12);
        end else begin
            m_axis_tready <= 1'b1;
            rx_hold <= $urandom_range(0, 23);
        end
    end

    always @(posedge i_clk) begin : result_check
        t_result got;
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.mask = m_axis_tdata[0];
            got.light_bit = m_axis_tdata[1];
            got.color_dilated = m_axis_tdata[2];
            got.last_pixel = m_axis_tlast;
            if (mask_results_due.size() == 0) begin
                note_failure($sformatf("result %b with none outstanding", got));
            end else begin
                want = mask_results_due.pop_front();
                if (got !== want)
                    note_failure($sformatf(
                        "mask %b light %b dilated %b last %b, expected %b %b %b %b",
                        got.mask, got.light_bit, got.color_dilated, got.last_pixel,
                        want.mask, want.light_bit, want.color_dilated, want.last_pixel));
            end
        end
    end

    initial begin : stimulus
        int unsigned w, h;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        check_reg(REG_IMAGE_WIDTH, 32'(RST_IMAGE_WIDTH));
        check_reg(REG_IMAGE_HEIGHT, 32'(RST_IMAGE_HEIGHT));
        check_reg(REG_COLOR_THRESHOLD, 32'(RST_COLOR_THRESHOLD));
        check_reg(REG_LIGHT_THRESHOLD, 32'(RST_LIGHT_THRESHOLD));

        set_config(1, 1, 32'(RST_COLOR_THRESHOLD), 32'(RST_LIGHT_THRESHOLD));
        foreach (directed_rows[i])
            send_item(directed_rows[i].kind,
                      {directed_rows[i].red, directed_rows[i].green, directed_rows[i].blue},
                      directed_rows[i].typed, directed_rows[i].want);
        wait_drained();

        // Geometry and threshold extremes. Zero sizes act as one, an oversized
        // width is clamped, and the tall frames are abandoned part way so that
        // the next geometry forces a restart.
        set_config(0, 0, 0, 0);
        send_frames(3, 0);
        wait_drained();
        set_config(4095, 1, 255, 255);
        send_frames(1, 0);
        wait_drained();
        set_config(2048, 4095, 0, 0);
        send_frames(1, 2100);
        wait_drained();
        set_config(1, 4095, 128, 100);
        send_frames(1, 60);
        wait_drained();

        random_items = 0;
        while (random_items < 600) begin
            calm = random_items >= 480;
            stalls_on = $urandom_range(0, 3) != 0;
            w = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(0, 8);
            h = $urandom_range(0, 6);
            set_config(w, h, $urandom_range(0, 255), $urandom_range(0, 255));
            send_frames($urandom_range(1, 3),
                        ($urandom_range(0, 3) == 0) ? $urandom_range(1, 50) : 0);
            wait_drained();
        end

        repeat (20) @(posedge i_clk);
        if (fail_count == 0 && mask_results_due.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin : watchdog
        #15_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== color_light_mask_pixel_stage.f =====
hw/rtl/clm_pkg.sv
hw/rtl/clm_out_fifo.sv
hw/rtl/color_light_mask_pixel_stage.sv
hw/rtl/clm_checker.sv
sim/testbench.sv
